// ===== hdl/rtr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtr_pkg
// Types, codes, compare and truncation helpers shared by the range table reclassifier.
// ----------------------------------------------------------------------------
package rtr_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int VALUE_BITS  = 32;

    localparam int IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CMP_W    = (IDX_W > 8) ? IDX_W : 8;
    localparam int ENTRY_W  = 7;
    localparam int COUNT_W  = 8;
    localparam int CTRL_W   = 9;
    localparam int DATA_W   = (VALUE_BITS > 32) ? 64 : 32;
    localparam int STRIDE_W = (VALUE_BITS > 32) ? 3 : 2;
    localparam int REG_W    = 3;
    localparam int ADDR_W   = REG_W + STRIDE_W;

    localparam int FRAC_BITS = 16;
    localparam int FRAC_ONE  = 65536;

    typedef logic signed [VALUE_BITS-1:0] t_val;

    localparam logic [REG_W-1:0] REG_CONTROL     = 3'd0;
    localparam logic [REG_W-1:0] REG_LOW_BOUND   = 3'd1;
    localparam logic [REG_W-1:0] REG_HIGH_BOUND  = 3'd2;
    localparam logic [REG_W-1:0] REG_REPLACE     = 3'd3;
    localparam logic [REG_W-1:0] REG_ND_MARKER   = 3'd4;
    localparam logic [REG_W-1:0] REG_ND_REPLACE  = 3'd5;
    localparam logic [REG_W-1:0] REG_OT_REPLACE  = 3'd6;
    localparam logic [REG_W-1:0] REG_ENTRY_COUNT = 3'd7;

    localparam logic [1:0] METH_SINGLE = 2'd0;
    localparam logic [1:0] METH_RANGE  = 2'd1;

    localparam logic [2:0] SOP_EQ = 3'd0;
    localparam logic [2:0] SOP_LT = 3'd1;
    localparam logic [2:0] SOP_LE = 3'd2;
    localparam logic [2:0] SOP_GE = 3'd3;
    localparam logic [2:0] SOP_GT = 3'd4;

    localparam logic [2:0] ROP_INCL = 3'd0;
    localparam logic [2:0] ROP_EXCL = 3'd1;

    localparam logic [2:0] TOP_LO_INCL  = 3'd0;
    localparam logic [2:0] TOP_BOTH     = 3'd1;
    localparam logic [2:0] TOP_HI_INCL  = 3'd2;
    localparam logic [2:0] TOP_NEITHER  = 3'd3;

    localparam logic [1:0] OUT_NODATA    = 2'd0;
    localparam logic [1:0] OUT_MATCH     = 2'd1;
    localparam logic [1:0] OUT_OTHER     = 2'd2;
    localparam logic [1:0] OUT_UNCHANGED = 2'd3;

    typedef struct packed {
        logic [CTRL_W-1:0]  control;
        t_val               low_bound;
        t_val               high_bound;
        t_val               replace_value;
        t_val               nodata_marker;
        t_val               nodata_replacement;
        t_val               other_replacement;
        logic [COUNT_W-1:0] entry_count;
    } t_cfg;

    typedef struct packed {
        logic               write;
        t_val               value;
        logic [ENTRY_W-1:0] index;
        t_val               lo;
        t_val               hi;
        t_val               code;
        logic               found;
        t_val               res;
        logic [ENTRY_W-1:0] hit;
    } t_beat;

    function automatic logic table_match(input logic [2:0] op, input t_val v,
                                         input t_val lo, input t_val hi);
        logic m;
        case (op)
            TOP_LO_INCL: m = (v >= lo) && (v < hi);
            TOP_BOTH:    m = (v >= lo) && (v <= hi);
            TOP_HI_INCL: m = (v > lo) && (v <= hi);
            TOP_NEITHER: m = (v > lo) && (v < hi);
            default:     m = 1'b0;
        endcase
        return m;
    endfunction

    function automatic t_val trunc_q(input t_val v);
        t_val base;
        base = {v[VALUE_BITS-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
        if (v[VALUE_BITS-1] && (|v[FRAC_BITS-1:0])) begin
            base = base + t_val'(FRAC_ONE);
        end
        return base;
    endfunction

endpackage

// ===== hdl/rtr_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtr_cell
// One table entry of the search chain: stores its interval and code, tests
// the passing beat against them and hands the beat on to the next cell.
// ----------------------------------------------------------------------------
module rtr_cell import rtr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [IDX_W-1:0] i_cell_idx,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    input  t_beat            i_beat,
    output logic             o_valid,
    output t_beat            o_beat
);

    t_val  r_lo;
    t_val  r_hi;
    t_val  r_code;
    logic  r_valid;
    t_beat r_beat;
    t_beat n_beat;
    logic  w_wr_hit;
    logic  w_active;

    assign w_wr_hit = i_valid && i_beat.write &&
                      (CMP_W'(i_beat.index) == CMP_W'(i_cell_idx));
    assign w_active = CMP_W'(i_cell_idx) < CMP_W'(i_cfg.entry_count);

    always_comb begin
        n_beat = i_beat;
        if (i_valid && !i_beat.write && !i_beat.found && w_active &&
            table_match(i_cfg.control[4:2], i_beat.value, r_lo, r_hi)) begin
            n_beat.found = 1'b1;
            n_beat.res   = r_code;
            n_beat.hit   = ENTRY_W'(i_cell_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
            if (w_wr_hit) begin
                r_lo   <= i_beat.lo;
                r_hi   <= i_beat.hi;
                r_code <= i_beat.code;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== hdl/rtr_resolve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtr_resolve
// End of the chain: applies table, single, range, no-data and other rules, the
// extract filter, and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module rtr_resolve import rtr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    input  t_beat              i_beat,
    output logic               o_valid,
    output t_val               o_value,
    output logic [1:0]         o_outcome,
    output logic [ENTRY_W-1:0] o_hit
);

    logic               r_valid;
    t_val               r_value;
    logic [1:0]         r_outcome;
    logic [ENTRY_W-1:0] r_hit;

    logic               n_valid;
    t_val               n_value;
    logic [1:0]         n_outcome;
    logic [ENTRY_W-1:0] n_hit;

    logic [1:0] w_method;
    logic [2:0] w_op;
    logic       w_is_table;
    t_val       w_v;
    logic       w_match;
    logic       w_nodata;

    assign w_method   = i_cfg.control[1:0];
    assign w_op       = i_cfg.control[4:2];
    assign w_is_table = (w_method != METH_SINGLE) && (w_method != METH_RANGE);
    assign w_v        = (!w_is_table && i_cfg.control[8]) ? trunc_q(i_beat.value)
                                                          : i_beat.value;
    assign w_nodata   = i_cfg.control[6] && (w_v == i_cfg.nodata_marker);

    always_comb begin
        w_match = 1'b0;
        if (w_method == METH_SINGLE) begin
            case (w_op)
                SOP_EQ:  w_match = w_v == i_cfg.low_bound;
                SOP_LT:  w_match = w_v <  i_cfg.low_bound;
                SOP_LE:  w_match = w_v <= i_cfg.low_bound;
                SOP_GE:  w_match = w_v >= i_cfg.low_bound;
                SOP_GT:  w_match = w_v >  i_cfg.low_bound;
                default: w_match = 1'b0;
            endcase
        end else begin
            case (w_op)
                ROP_INCL: w_match = (i_cfg.low_bound <= w_v) && (w_v <= i_cfg.high_bound);
                ROP_EXCL: w_match = (i_cfg.low_bound <  w_v) && (w_v <  i_cfg.high_bound);
                default:  w_match = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_outcome = OUT_UNCHANGED;
        n_value   = w_v;
        n_hit     = '0;
        if (w_is_table) begin
            if (i_beat.found) begin
                n_outcome = OUT_MATCH;
                n_value   = i_beat.res;
                n_hit     = i_beat.hit;
            end else if (w_nodata) begin
                n_outcome = OUT_NODATA;
                n_value   = i_cfg.nodata_replacement;
            end
        end else if (w_nodata) begin
            n_outcome = OUT_NODATA;
            n_value   = i_cfg.nodata_replacement;
        end else if (w_match) begin
            n_outcome = OUT_MATCH;
            n_value   = i_cfg.replace_value;
        end
        if (n_outcome == OUT_UNCHANGED && i_cfg.control[7] &&
            (w_v != i_cfg.nodata_marker)) begin
            n_outcome = OUT_OTHER;
            n_value   = i_cfg.other_replacement;
        end
        n_valid = i_valid && !i_beat.write;
        if (i_cfg.control[5]) begin
            n_value = i_beat.value;
            if (n_outcome == OUT_UNCHANGED) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value   <= n_value;
            r_outcome <= n_outcome;
            r_hit     <= n_hit;
        end
    end

    assign o_valid   = r_valid;
    assign o_value   = r_value;
    assign o_outcome = r_outcome;
    assign o_hit     = r_hit;

endmodule

// ===== hdl/range_table_reclassifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_table_reclassifier_top
// Pipeline: each input beat passes through the register of every cell of the
// search chain in turn, then through the output register.
// Throughput: one beat per cycle; the whole chain holds while a result
// beat waits under stall.
// Reset: control and configuration registers take their reset values and
// the chain empties; table entries are undefined until written.
// ----------------------------------------------------------------------------
module range_table_reclassifier_top import rtr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  t_val               i_point_value,
    input  logic [ENTRY_W-1:0] i_entry_index,
    input  t_val               i_entry_low,
    input  t_val               i_entry_high,
    input  t_val               i_entry_code,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_val               o_out_value,
    output logic [1:0]         o_outcome,
    output logic [ENTRY_W-1:0] o_hit_entry
);

    t_cfg             r_cfg;
    t_cfg             n_cfg;
    logic [REG_W-1:0] w_reg;
    logic             w_adv;
    logic             w_valid [TABLE_DEPTH+1];
    t_beat            w_beat  [TABLE_DEPTH+1];

    assign pready = 1'b1;
    assign w_reg  = paddr[ADDR_W-1:STRIDE_W];

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (w_reg)
                REG_CONTROL:     n_cfg.control            = pwdata[CTRL_W-1:0];
                REG_LOW_BOUND:   n_cfg.low_bound          = pwdata[VALUE_BITS-1:0];
                REG_HIGH_BOUND:  n_cfg.high_bound         = pwdata[VALUE_BITS-1:0];
                REG_REPLACE:     n_cfg.replace_value      = pwdata[VALUE_BITS-1:0];
                REG_ND_MARKER:   n_cfg.nodata_marker      = pwdata[VALUE_BITS-1:0];
                REG_ND_REPLACE:  n_cfg.nodata_replacement = pwdata[VALUE_BITS-1:0];
                REG_OT_REPLACE:  n_cfg.other_replacement  = pwdata[VALUE_BITS-1:0];
                REG_ENTRY_COUNT: n_cfg.entry_count        = pwdata[COUNT_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.control            <= '0;
            r_cfg.low_bound          <= '0;
            r_cfg.high_bound         <= t_val'(655360);
            r_cfg.replace_value      <= t_val'(65536);
            r_cfg.nodata_marker      <= '0;
            r_cfg.nodata_replacement <= '0;
            r_cfg.other_replacement  <= '0;
            r_cfg.entry_count        <= COUNT_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_reg)
            REG_CONTROL:     prdata = DATA_W'(r_cfg.control);
            REG_LOW_BOUND:   prdata = DATA_W'(r_cfg.low_bound);
            REG_HIGH_BOUND:  prdata = DATA_W'(r_cfg.high_bound);
            REG_REPLACE:     prdata = DATA_W'(r_cfg.replace_value);
            REG_ND_MARKER:   prdata = DATA_W'(r_cfg.nodata_marker);
            REG_ND_REPLACE:  prdata = DATA_W'(r_cfg.nodata_replacement);
            REG_OT_REPLACE:  prdata = DATA_W'(r_cfg.other_replacement);
            REG_ENTRY_COUNT: prdata = DATA_W'(r_cfg.entry_count);
            default:         prdata = '0;
        endcase
    end

    // chain moves whenever the output register can take a beat
    assign w_adv      = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    assign w_valid[0] = i_in_valid;
    assign w_beat[0]  = {i_operation, i_point_value, i_entry_index, i_entry_low,
                         i_entry_high, i_entry_code, 1'b0, {VALUE_BITS{1'b0}},
                         {ENTRY_W{1'b0}}};

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        rtr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (w_adv),
            .i_cell_idx (IDX_W'(g)),
            .i_cfg      (r_cfg),
            .i_valid    (w_valid[g]),
            .i_beat     (w_beat[g]),
            .o_valid    (w_valid[g+1]),
            .o_beat     (w_beat[g+1])
        );
    end

    rtr_resolve u_resolve (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_cfg     (r_cfg),
        .i_valid   (w_valid[TABLE_DEPTH]),
        .i_beat    (w_beat[TABLE_DEPTH]),
        .o_valid   (o_out_valid),
        .o_value   (o_out_value),
        .o_outcome (o_outcome),
        .o_hit     (o_hit_entry)
    );

endmodule
